### hdl/fdtd1d_pkg.sv
// Shared constants, register map and state types for the 1-D FDTD field update block.
`default_nettype none

package fdtd1d_pkg;

    // Array size and port widths
    localparam int CELLS_DEFAULT = 64;
    localparam int FIELD_W       = 32;
    localparam int COEF_W        = 32;
    localparam int SRC_W         = 6;
    localparam int DATA_W        = 32;
    localparam int PADDR_W       = 5;
    localparam int REG_IDX_W     = PADDR_W - 2;

    // Fixed-point arithmetic: Q16.16 fields times Q8.24 coefficients
    localparam int COEF_FRAC = 24;
    localparam int PROD_W    = COEF_W + FIELD_W + 1;
    localparam int ACC_W     = PROD_W + 1;
    localparam int RQ_W      = ACC_W - COEF_FRAC;

    localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

    // Register map, index = paddr / 4
    localparam logic [REG_IDX_W-1:0] REG_E_DECAY       = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_E_CURL_GAIN   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_E_SOURCE_GAIN = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_H_CURL_GAIN   = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_SOURCE_CELL   = REG_IDX_W'(4);

    // Register reset values
    localparam logic signed [COEF_W-1:0] E_DECAY_RST     = COEF_W'(32'h0100_0000);
    localparam logic [SRC_W-1:0]         SOURCE_CELL_RST = SRC_W'(32);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_E_PRIME,
        ST_E_RUN,
        ST_E_DRAIN,
        ST_H_RUN,
        ST_H_DRAIN,
        ST_FINISH
    } state_t;

    // Operation issued to the shared multiplier
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PRIME,
        OP_E_SELF,
        OP_E_CURL,
        OP_E_SRC,
        OP_H_CURL
    } op_t;

endpackage

`default_nettype wire

### hdl/fdtd1d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fdtd1d_ram #(
    parameter int WIDTH = fdtd1d_pkg::FIELD_W,
    parameter int DEPTH = fdtd1d_pkg::CELLS_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/fdtd_1d_field_update_top.sv
// Top level of the 1-D FDTD field update: sequencer, shared multiplier, field RAMs, APB registers.
// Time steps pass one at a time through the single 32x33 multiplier:
// two products per electric cell (three at the source cell), one per magnetic cell.
// Reset: registers return to defaults, then a clearing pass zeroes both
// field RAMs before the first input transfer is taken.
`default_nettype none

module fdtd_1d_field_update_top #(
    parameter int CELLS = fdtd1d_pkg::CELLS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [fdtd1d_pkg::PADDR_W-1:0]        paddr,
    input  logic [fdtd1d_pkg::DATA_W-1:0]         pwdata,
    output logic [fdtd1d_pkg::DATA_W-1:0]         prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [fdtd1d_pkg::FIELD_W-1:0] source_current,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [fdtd1d_pkg::FIELD_W-1:0] probe_field,
    output logic                                  saturated
);
    import fdtd1d_pkg::*;

    localparam int CW  = $clog2(CELLS);
    localparam int HAW = $clog2(CELLS - 1);
    localparam int XW  = (CW > SRC_W) ? CW : SRC_W;

    localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 2);
    localparam logic [CW-1:0] END_CELL  = CW'(CELLS - 1);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC - 1);

    // Configuration registers
    logic signed [COEF_W-1:0] e_decay_reg;
    logic signed [COEF_W-1:0] e_curl_gain_reg;
    logic signed [COEF_W-1:0] e_source_gain_reg;
    logic signed [COEF_W-1:0] h_curl_gain_reg;
    logic [SRC_W-1:0]         source_cell_reg;
    logic                     cfg_we;
    logic [REG_IDX_W-1:0]     cfg_idx;

    // Sequencer
    state_t         state_reg, state_next;
    logic [CW-1:0]  x_reg, x_next;
    op_t            eop_reg, eop_next;
    op_t            s0_op;
    logic           s0_last;
    logic           cell_done;
    logic           is_src_s0;
    logic           e_re, h_re;
    logic [CW-1:0]  e_raddr, h_raddr;
    logic           clr_we;
    logic           start;
    logic           load_out;
    logic           pipe_empty;

    // Pipeline stages
    op_t            s1_op_reg;
    logic           s1_last_reg;
    logic [CW-1:0]  s1_cell_reg;
    op_t            s2_op_reg;
    logic           s2_last_reg;
    logic [CW-1:0]  s2_cell_reg;
    logic           wr_valid_reg;
    logic           wr_is_e_reg;
    logic [CW-1:0]  wr_cell_reg;

    // Datapath
    logic signed [FIELD_W-1:0] e_rd, h_rd;
    logic signed [FIELD_W-1:0] hprev_reg, eprev_reg, cur_reg;
    logic signed [COEF_W-1:0]  mul_a;
    logic signed [FIELD_W:0]   mul_b;
    logic signed [PROD_W-1:0]  prod_next, prod_reg;
    logic signed [FIELD_W-1:0] base_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next, acc_init;
    logic                      s2_first;
    logic signed [ACC_W-1:0]   rsum;
    logic signed [RQ_W-1:0]    rq;
    logic                      res_fits;
    logic signed [FIELD_W-1:0] res_value;
    logic                      wr_is_src;

    // Result registers
    logic signed [FIELD_W-1:0] probe_reg, probe_out_reg;
    logic                      sat_reg, sat_out_reg;
    logic                      out_valid_reg;

    // RAM ports
    logic                      e_we, h_we;
    logic [CW-1:0]             e_waddr, h_waddr;
    logic [FIELD_W-1:0]        e_wdata, h_wdata;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_decay_reg       <= E_DECAY_RST;
            e_curl_gain_reg   <= '0;
            e_source_gain_reg <= '0;
            h_curl_gain_reg   <= '0;
            source_cell_reg   <= SOURCE_CELL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_E_DECAY:       e_decay_reg       <= pwdata[COEF_W-1:0];
                REG_E_CURL_GAIN:   e_curl_gain_reg   <= pwdata[COEF_W-1:0];
                REG_E_SOURCE_GAIN: e_source_gain_reg <= pwdata[COEF_W-1:0];
                REG_H_CURL_GAIN:   h_curl_gain_reg   <= pwdata[COEF_W-1:0];
                REG_SOURCE_CELL:   source_cell_reg   <= pwdata[SRC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back registers
    always_comb
    begin
        case (cfg_idx)
            REG_E_DECAY:       prdata = e_decay_reg;
            REG_E_CURL_GAIN:   prdata = e_curl_gain_reg;
            REG_E_SOURCE_GAIN: prdata = e_source_gain_reg;
            REG_H_CURL_GAIN:   prdata = h_curl_gain_reg;
            REG_SOURCE_CELL:   prdata = DATA_W'(source_cell_reg);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign is_src_s0  = (XW'(x_reg) == XW'(source_cell_reg));
    assign pipe_empty = (s1_op_reg == OP_NONE) && (s2_op_reg == OP_NONE) && !wr_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            x_reg     <= '0;
            eop_reg   <= OP_E_SELF;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            eop_reg   <= eop_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        eop_next   = eop_reg;
        s0_op      = OP_NONE;
        s0_last    = 1'b0;
        cell_done  = 1'b0;
        e_re       = 1'b0;
        h_re       = 1'b0;
        e_raddr    = x_reg;
        h_raddr    = x_reg;
        clr_we     = 1'b0;
        in_stall   = 1'b1;
        start      = 1'b0;
        load_out   = 1'b0;

        case (state_reg)
            // Zero both field RAMs, one cell per cycle
            ST_CLEAR:
            begin
                clr_we = 1'b1;
                if (x_reg == END_CELL)
                begin
                    x_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    x_next = x_reg + CW'(1);
                end
            end

            // Take the next time step
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    start      = 1'b1;
                    state_next = ST_E_PRIME;
                end
            end

            // Fetch the magnetic cell left of the first electric cell
            ST_E_PRIME:
            begin
                s0_op      = OP_PRIME;
                h_re       = 1'b1;
                h_raddr    = '0;
                x_next     = CW'(1);
                eop_next   = OP_E_SELF;
                state_next = ST_E_RUN;
            end

            // Electric sweep: self term, curl term, source term at the source cell
            ST_E_RUN:
            begin
                s0_op = eop_reg;
                case (eop_reg)
                    OP_E_SELF:
                    begin
                        e_re     = 1'b1;
                        h_re     = 1'b1;
                        eop_next = OP_E_CURL;
                    end
                    OP_E_CURL:
                    begin
                        if (is_src_s0)
                        begin
                            eop_next = OP_E_SRC;
                        end
                        else
                        begin
                            cell_done = 1'b1;
                        end
                    end
                    OP_E_SRC:
                    begin
                        cell_done = 1'b1;
                    end
                    default:
                    begin
                        eop_next = OP_E_SELF;
                    end
                endcase
                s0_last = cell_done;
                if (cell_done)
                begin
                    eop_next = OP_E_SELF;
                    if (x_reg == LAST_CELL)
                    begin
                        x_next     = '0;
                        state_next = ST_E_DRAIN;
                    end
                    else
                    begin
                        x_next = x_reg + CW'(1);
                    end
                end
            end

            // Let the last electric write land before the magnetic sweep reads it
            ST_E_DRAIN:
            begin
                if (pipe_empty)
                begin
                    x_next     = '0;
                    state_next = ST_H_RUN;
                end
            end

            // Magnetic sweep: one product per cell
            ST_H_RUN:
            begin
                s0_op   = OP_H_CURL;
                s0_last = 1'b1;
                e_re    = 1'b1;
                h_re    = 1'b1;
                e_raddr = x_reg + CW'(1);
                h_raddr = x_reg;
                if (x_reg == LAST_CELL)
                begin
                    x_next     = '0;
                    state_next = ST_H_DRAIN;
                end
                else
                begin
                    x_next = x_reg + CW'(1);
                end
            end

            ST_H_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end

            // Hand the result to the output register once it is free
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg     <= OP_NONE;
            s1_last_reg   <= 1'b0;
            s2_op_reg     <= OP_NONE;
            s2_last_reg   <= 1'b0;
            wr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_op_reg    <= s0_op;
            s1_last_reg  <= s0_last;
            s2_op_reg    <= (s1_op_reg == OP_PRIME) ? OP_NONE : s1_op_reg;
            s2_last_reg  <= s1_last_reg;
            wr_valid_reg <= (s2_op_reg != OP_NONE) && s2_last_reg;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: select operands for the shared multiplier
    // ------------------------------------------------------------------
    always_comb
    begin
        case (s1_op_reg)
            OP_E_SELF:
            begin
                mul_a = e_decay_reg;
                mul_b = (FIELD_W+1)'(e_rd);
            end
            OP_E_CURL:
            begin
                mul_a = e_curl_gain_reg;
                mul_b = (FIELD_W+1)'(hprev_reg) - (FIELD_W+1)'(h_rd);
            end
            OP_E_SRC:
            begin
                mul_a = e_source_gain_reg;
                mul_b = (FIELD_W+1)'(0) - (FIELD_W+1)'(cur_reg);
            end
            OP_H_CURL:
            begin
                mul_a = h_curl_gain_reg;
                mul_b = (FIELD_W+1)'(eprev_reg) - (FIELD_W+1)'(e_rd);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // ------------------------------------------------------------------
    // Stage 2: exact accumulation
    // ------------------------------------------------------------------
    assign s2_first = (s2_op_reg == OP_E_SELF) || (s2_op_reg == OP_H_CURL);
    assign acc_init = ACC_W'(base_reg) <<< COEF_FRAC;
    assign acc_next = (s2_first ? acc_init : acc_reg) + ACC_W'(prod_reg);

    // ------------------------------------------------------------------
    // Stage 3: round half up to Q16.16 and clamp
    // ------------------------------------------------------------------
    assign rsum     = acc_reg + ROUND_HALF;
    assign rq       = rsum[ACC_W-1:COEF_FRAC];
    assign res_fits = (&rq[RQ_W-1:FIELD_W-1]) || !(|rq[RQ_W-1:FIELD_W-1]);

    always_comb
    begin
        if (res_fits)
        begin
            res_value = rq[FIELD_W-1:0];
        end
        else if (rq[RQ_W-1])
        begin
            res_value = FIELD_MIN;
        end
        else
        begin
            res_value = FIELD_MAX;
        end
    end

    assign wr_is_src = (XW'(wr_cell_reg) == XW'(source_cell_reg));

    // Datapath registers
    always_ff @(posedge clk)
    begin
        s1_cell_reg <= x_reg;
        s2_cell_reg <= s1_cell_reg;
        wr_cell_reg <= s2_cell_reg;
        wr_is_e_reg <= (s2_op_reg != OP_H_CURL);

        // Slide the left neighbor along each sweep
        if ((s1_op_reg == OP_PRIME) || (s1_op_reg == OP_E_CURL))
        begin
            hprev_reg <= h_rd;
        end
        if (state_reg == ST_E_DRAIN)
        begin
            eprev_reg <= '0;
        end
        else if (s1_op_reg == OP_H_CURL)
        begin
            eprev_reg <= e_rd;
        end

        prod_reg <= prod_next;
        base_reg <= (s1_op_reg == OP_H_CURL) ? h_rd : '0;

        if (s2_op_reg != OP_NONE)
        begin
            acc_reg <= acc_next;
        end

        // Latch the current sample, collect probe and clamp flag over the step
        if (start)
        begin
            cur_reg   <= source_current;
            probe_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (wr_valid_reg)
        begin
            if (!res_fits)
            begin
                sat_reg <= 1'b1;
            end
            if (wr_is_e_reg && wr_is_src)
            begin
                probe_reg <= res_value;
            end
        end

        if (load_out)
        begin
            probe_out_reg <= probe_reg;
            sat_out_reg   <= sat_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign probe_field = probe_out_reg;
    assign saturated   = sat_out_reg;

    // ------------------------------------------------------------------
    // Field memories
    // ------------------------------------------------------------------
    assign e_we    = clr_we || (wr_valid_reg && wr_is_e_reg);
    assign e_waddr = clr_we ? x_reg : wr_cell_reg;
    assign e_wdata = clr_we ? '0 : res_value;

    assign h_we    = (clr_we && (x_reg != END_CELL)) || (wr_valid_reg && !wr_is_e_reg);
    assign h_waddr = clr_we ? x_reg : wr_cell_reg;
    assign h_wdata = clr_we ? '0 : res_value;

    fdtd1d_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (CELLS)
    ) u_e_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .re    (e_re),
        .raddr (e_raddr),
        .rdata (e_rd)
    );

    fdtd1d_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (CELLS - 1)
    ) u_h_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr[HAW-1:0]),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr[HAW-1:0]),
        .rdata (h_rd)
    );

endmodule

`default_nettype wire
